// ===== rtl/crc8_frame_packer_defines.svh =====
// Shared assertion macros for the frame packer.
`ifndef CRC8_FRAME_PACKER_DEFINES_SVH
`define CRC8_FRAME_PACKER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define CRC8FP_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error("crc8_frame_packer: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define CRC8FP_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error("crc8_frame_packer: next-cycle check failed");

`endif

// ===== rtl/crc8fp_pkg.sv =====
package crc8fp_pkg;

    // Framing constants
    localparam logic [7:0] FRAME_HEAD  = 8'h7E;
    localparam logic [7:0] FRAME_TAIL  = 8'h7D;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] FRAME_EXTRA = 8'd13;

    // Command kinds passed from front to back
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // Serializer step numbers
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR_LAST = 4'd10;
    localparam logic [STEP_W-1:0] STEP_HDR_CRC  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_HDR_TAIL = 4'd12;
    localparam logic [STEP_W-1:0] STEP_PAY_CRC  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PAY_TAIL = 4'd2;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic       close;       // payload byte ends the frame
        logic       empty_frame; // header with no payload
        logic [7:0] local_address;
        logic [7:0] data_kind;
        logic [7:0] length_byte;
        logic [7:0] device_kind;
        logic [7:0] brand;
        logic [7:0] target_address;
        logic [7:0] target_channel;
        logic [7:0] spare_one;
        logic [7:0] spare_two;
        logic [7:0] spare_three;
        logic [7:0] payload_byte;
    } cmd_t;

    // CRC-8, polynomial 0x07, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc8fp_front.sv =====
module crc8fp_front #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [7:0]         cfg_write_data,
    input  logic               accept,
    input  logic               req_type,
    input  logic [7:0]         data_kind,
    input  logic [7:0]         device_kind,
    input  logic [7:0]         brand,
    input  logic [7:0]         target_address,
    input  logic [7:0]         target_channel,
    input  logic [7:0]         spare_one,
    input  logic [7:0]         spare_two,
    input  logic [7:0]         spare_three,
    input  logic [5:0]         payload_length,
    input  logic [7:0]         payload_byte,
    output crc8fp_pkg::cmd_t   cmd
);
    import crc8fp_pkg::*;

    localparam int LEN_LIMIT = BUFFER_BYTES - 2;

    logic [7:0] local_address_reg;
    logic       frame_open_reg, frame_open_next;
    logic [5:0] remaining_reg, remaining_next;
    logic       too_long;

    assign too_long = ({2'b00, payload_length} >= 8'(LEN_LIMIT));

    // Classify the incoming transaction and track frame state
    always_comb
    begin
        frame_open_next    = frame_open_reg;
        remaining_next     = remaining_reg;
        cmd.kind           = KIND_ERR;
        cmd.close          = 1'b0;
        cmd.empty_frame    = (payload_length == 6'd0);
        cmd.local_address  = local_address_reg;
        cmd.data_kind      = data_kind;
        cmd.length_byte    = FRAME_EXTRA + {2'b00, payload_length};
        cmd.device_kind    = device_kind;
        cmd.brand          = brand;
        cmd.target_address = target_address;
        cmd.target_channel = target_channel;
        cmd.spare_one      = spare_one;
        cmd.spare_two      = spare_two;
        cmd.spare_three    = spare_three;
        cmd.payload_byte   = payload_byte;
        if (!req_type)
        begin
            if (too_long)
            begin
                frame_open_next = 1'b0;
                remaining_next  = 6'd0;
            end
            else
            begin
                cmd.kind        = KIND_HDR;
                frame_open_next = (payload_length != 6'd0);
                remaining_next  = payload_length;
            end
        end
        else if (frame_open_reg && remaining_reg != 6'd0)
        begin
            cmd.kind        = KIND_PAY;
            cmd.close       = (remaining_reg == 6'd1);
            remaining_next  = remaining_reg - 6'd1;
            frame_open_next = (remaining_reg != 6'd1);
        end
    end

    // Hold frame state and the address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg    <= 1'b0;
            remaining_reg     <= 6'd0;
            local_address_reg <= 8'd0;
        end
        else
        begin
            if (accept)
            begin
                frame_open_reg <= frame_open_next;
                remaining_reg  <= remaining_next;
            end
            if (cfg_write_en)
            begin
                local_address_reg <= cfg_write_data;
            end
        end
    end

endmodule

// ===== rtl/crc8fp_queue.sv =====
module crc8fp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crc8fp_pkg::cmd_t cmd_in,
    output logic             full,
    input  logic             pop,
    output crc8fp_pkg::cmd_t head,
    output logic             head_valid
);
    import crc8fp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Store commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/crc8fp_back.sv =====
`include "crc8_frame_packer_defines.svh"

module crc8fp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  crc8fp_pkg::cmd_t head,
    input  logic             head_valid,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             end_of_frame,
    output logic             last_in_run,
    output logic             error
);
    import crc8fp_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [7:0]        crc_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              eof_reg, last_reg, err_reg;

    logic              advance, work, done, is_data;
    logic [7:0]        byte_sel, crc_in, crc_next;
    logic              eof_sel, last_sel, err_sel;

    assign advance = !out_valid_reg || !out_stall;
    assign work    = head_valid && advance;
    assign pop     = work && done;

    // Pick the byte for the current step of the head command
    always_comb
    begin
        byte_sel = 8'h00;
        eof_sel  = 1'b0;
        last_sel = 1'b0;
        err_sel  = 1'b0;
        done     = 1'b0;
        is_data  = 1'b0;
        case (head.kind)
            KIND_HDR:
            begin
                is_data = (step_reg <= STEP_HDR_LAST);
                case (step_reg)
                    4'd0:    byte_sel = FRAME_HEAD;
                    4'd1:    byte_sel = head.local_address;
                    4'd2:    byte_sel = head.data_kind;
                    4'd3:    byte_sel = head.length_byte;
                    4'd4:    byte_sel = head.device_kind;
                    4'd5:    byte_sel = head.brand;
                    4'd6:    byte_sel = head.target_address;
                    4'd7:    byte_sel = head.target_channel;
                    4'd8:    byte_sel = head.spare_one;
                    4'd9:    byte_sel = head.spare_two;
                    4'd10:   byte_sel = head.spare_three;
                    4'd11:   byte_sel = crc_reg;
                    default: byte_sel = FRAME_TAIL;
                endcase
                if (step_reg == STEP_HDR_LAST && !head.empty_frame)
                begin
                    last_sel = 1'b1;
                    done     = 1'b1;
                end
                if (step_reg == STEP_HDR_TAIL)
                begin
                    eof_sel  = 1'b1;
                    last_sel = 1'b1;
                    done     = 1'b1;
                end
            end
            KIND_PAY:
            begin
                case (step_reg)
                    STEP_FIRST:
                    begin
                        is_data  = 1'b1;
                        byte_sel = head.payload_byte;
                        last_sel = !head.close;
                        done     = !head.close;
                    end
                    STEP_PAY_CRC:
                    begin
                        byte_sel = crc_reg;
                    end
                    default:
                    begin
                        byte_sel = FRAME_TAIL;
                        eof_sel  = 1'b1;
                        last_sel = 1'b1;
                        done     = 1'b1;
                    end
                endcase
            end
            default:
            begin
                eof_sel  = 1'b1;
                last_sel = 1'b1;
                err_sel  = 1'b1;
                done     = 1'b1;
            end
        endcase
    end

    // Restart the CRC on the opening flag of each frame
    assign crc_in   = (head.kind == KIND_HDR && step_reg == STEP_FIRST) ? 8'h00 : crc_reg;
    assign crc_next = crc8_byte(crc_in, byte_sel);

    // Advance the step counter, the CRC and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            crc_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= head_valid;
            end
            if (work)
            begin
                step_reg <= done ? STEP_FIRST : step_reg + 1'b1;
                if (is_data)
                begin
                    crc_reg <= crc_next;
                end
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_byte_reg <= byte_sel;
            eof_reg      <= eof_sel;
            last_reg     <= last_sel;
            err_reg      <= err_sel;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign end_of_frame = eof_reg;
    assign last_in_run  = last_reg;
    assign error        = err_reg;

    `CRC8FP_ASSERT_IMP(a_step_range, clk, rst_n, 1'b1, step_reg <= STEP_HDR_TAIL)
    `CRC8FP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, head_valid)
    `CRC8FP_ASSERT_NXT(a_pop_restarts, clk, rst_n, pop, step_reg == STEP_FIRST)
    `CRC8FP_ASSERT_IMP(a_err_shape, clk, rst_n, out_valid_reg && err_reg, eof_reg && last_reg && out_byte_reg == 8'h00)

endmodule

// ===== rtl/crc8_frame_packer.sv =====
// Frame packer: a header transaction opens a frame and produces eleven output bytes (flag,
// address, data type, length, device type, brand, target address, target channel and three
// spare bytes); each payload transaction produces one byte, and the last one adds the CRC-8
// (poly 0x07, init 0, covering flag through payload) and the 0x7D tail, so it produces three.
// An empty-payload header produces thirteen bytes. Bad requests give a single error byte.
// Payload transactions are taken one per cycle while the command queue is not full; the
// output serializer emits one byte per cycle while out_stall is low. A two-entry command
// queue between the classifier and the serializer lets input keep flowing while the
// serializer or the downstream stall is busy.
module crc8_frame_packer #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] data_kind,
    input  logic [7:0] device_kind,
    input  logic [7:0] brand,
    input  logic [7:0] target_address,
    input  logic [7:0] target_channel,
    input  logic [7:0] spare_one,
    input  logic [7:0] spare_two,
    input  logic [7:0] spare_three,
    input  logic [5:0] payload_length,
    input  logic [7:0] payload_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       end_of_frame,
    output logic       last_in_run,
    output logic       error
);
    import crc8fp_pkg::*;

    cmd_t cmd, head;
    logic accept, full, pop, head_valid;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Classify transactions
    crc8fp_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accept         (accept),
        .req_type       (req_type),
        .data_kind      (data_kind),
        .device_kind    (device_kind),
        .brand          (brand),
        .target_address (target_address),
        .target_channel (target_channel),
        .spare_one      (spare_one),
        .spare_two      (spare_two),
        .spare_three    (spare_three),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .cmd            (cmd)
    );

    // Buffer commands
    crc8fp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .cmd_in     (cmd),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // Serialize frame bytes
    crc8fp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .last_in_run  (last_in_run),
        .error        (error)
    );

endmodule
